[rtl/rbss_pkg.sv]
// package for the rotated bilinear sprite sampler
// shared constants and config struct; no dependencies
`timescale 1ns / 1ps
package rbss_pkg;
	localparam int MAX_DIM_DEF = 128;
	localparam int COORD_FRAC_DEF = 8;
	localparam int ROT_FRAC = 14;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd6;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

	typedef struct packed {
		logic signed [15:0] cos_coef;
		logic signed [15:0] sin_coef;
		logic mirror_x;
		logic [7:0] img_width;
		logic [7:0] img_height;
		logic [8:0] center_x;
		logic [8:0] center_y;
	} cfg_t;
endpackage

[rtl/rbss_if.sv]
// valid/ready channel interface carrying a generic payload
// depends on nothing
`timescale 1ns / 1ps
interface rbss_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/rotated_bilinear_sprite_sampler.sv]
// top level of the rotated bilinear sprite sampler
// depends on rbss_pkg, rbss_if, rbss_front, rbss_back
//
//  channel  dir  payload                                            accepted when
//  in_ch    in   func, load_addr, load_gray, load_alpha, offset_x/y valid && ready
//  out_ch   out  screen_x, screen_y, pixel_value                    valid && ready
//  cfg      in   cfg_we, cfg_idx, cfg_data                          cfg_we high
//
// one item per clock sustained while the output is not stalled
// the front keeps two rotate stages and a four-entry queue, the back a
// seven-stage filter with four simple dual-port store copies (one per bilinear tap)
// arst_n clears control and config; the sprite store holds garbage until loaded
// a stall at the output freezes the back, and the queue lets the front run on
`timescale 1ns / 1ps
module rotated_bilinear_sprite_sampler import rbss_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
	input logic clk,
	input logic arst_n,
	rbss_if.sink in_ch,
	rbss_if.source out_ch,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_W-1:0] cfg_data
);
	localparam int AW = 14;
	// source coordinate: rotated offset plus half size, with sign
	localparam int CW = COORD_FRAC_BITS + 12;
	localparam int QW = 1 + AW + 16 + 22 + 2 * CW;

	// in_ch.data: {offset_y, offset_x, load_alpha, load_gray, load_addr, func}
	// out_ch.data: {pixel_value, screen_y, screen_x}
	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_coef <= 16'sd16384;
			cfg_q.sin_coef <= '0;
			cfg_q.mirror_x <= 1'b0;
			cfg_q.img_width <= 8'd128;
			cfg_q.img_height <= 8'd128;
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COS: cfg_q.cos_coef <= cfg_data;
				REG_SIN: cfg_q.sin_coef <= cfg_data;
				REG_MIRROR: cfg_q.mirror_x <= cfg_data[0];
				REG_WIDTH: cfg_q.img_width <= cfg_data[7:0];
				REG_HEIGHT: cfg_q.img_height <= cfg_data[7:0];
				REG_CX: cfg_q.center_x <= cfg_data[8:0];
				REG_CY: cfg_q.center_y <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic q_valid, q_ready;
	logic [QW-1:0] q_data;
	logic [10:0] ox, oy;
	logic [7:0] op;

	// front: accept, rotate, queue
	rbss_front #(.MAX_DIM(MAX_DIM), .FB(COORD_FRAC_BITS), .AW(AW), .CW(CW), .QW(QW)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_func(in_ch.data[0]), .in_addr(in_ch.data[14:1]),
		.in_gray(in_ch.data[22:15]), .in_alpha(in_ch.data[30:23]),
		.in_dx(in_ch.data[39:31]), .in_dy(in_ch.data[48:40]),
		.q_valid, .q_ready, .q_data
	);

	// back: store, filter, blend
	rbss_back #(.MAX_DIM(MAX_DIM), .FB(COORD_FRAC_BITS), .AW(AW), .CW(CW), .QW(QW)) u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.q_valid, .q_ready, .q_data,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_x(ox), .out_y(oy), .out_pix(op)
	);
	assign out_ch.data = {op, oy, ox};
endmodule

[rtl/rbss_front.sv]
// front part: accepts items, rotates the offset and queues
// depends on rbss_pkg
`timescale 1ns / 1ps
module rbss_front import rbss_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int FB = COORD_FRAC_DEF,
	parameter int AW = 14,
	parameter int CW = 24,
	parameter int QW = 1 + AW + 16 + 22 + 2 * CW
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic in_func,
	input logic [13:0] in_addr,
	input logic [7:0] in_gray,
	input logic [7:0] in_alpha,
	input logic signed [8:0] in_dx,
	input logic signed [8:0] in_dy,
	output logic q_valid,
	input logic q_ready,
	output logic [QW-1:0] q_data
);
	localparam int DROP = ROT_FRAC - FB;
	// stage 1: products
	logic v_s1, func_s1;
	logic [AW-1:0] addr_s1;
	logic [15:0] ld_s1;
	logic signed [8:0] dx_s1, dy_s1;
	logic signed [25:0] pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic [7:0] w_s1, h_s1;
	logic [QW-1:0] fifo_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] fill_q;
	logic v_s2;
	logic [QW-1:0] d_s2;
	logic [7:0] we, he;
	logic signed [27:0] sx, sy;
	logic signed [CW-1:0] xr, yr;
	logic push, pop;

	assign we = (32'(cfg.img_width) > MAX_DIM) ? 8'(MAX_DIM) : cfg.img_width;
	assign he = (32'(cfg.img_height) > MAX_DIM) ? 8'(MAX_DIM) : cfg.img_height;
	// accept while queue has room for everything in flight
	assign in_ready = (fill_q + {2'b0, v_s1} + {2'b0, v_s2}) < 3'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= in_func;
		addr_s1 <= AW'(in_addr);
		ld_s1 <= {in_alpha, in_gray};
		dx_s1 <= in_dx;
		dy_s1 <= in_dy;
		pxc_s1 <= in_dx * cfg.cos_coef;
		pys_s1 <= in_dy * cfg.sin_coef;
		pyc_s1 <= in_dy * cfg.cos_coef;
		pxs_s1 <= in_dx * cfg.sin_coef;
		w_s1 <= we;
		h_s1 <= he;
	end

	always_comb begin
		sx = 28'(pxc_s1) + 28'(pys_s1);
		sy = 28'(pyc_s1) - 28'(pxs_s1);
		if (cfg.mirror_x) sx = -sx;
		xr = CW'((sx + 28'(1 <<< (DROP - 1))) >>> DROP) + CW'({w_s1, {(FB - 1){1'b0}}});
		yr = CW'((sy + 28'(1 <<< (DROP - 1))) >>> DROP) + CW'({h_s1, {(FB - 1){1'b0}}});
	end

	always_ff @(posedge clk) begin
		d_s2 <= {func_s1, addr_s1, ld_s1, 11'(cfg.center_x) + 11'(dx_s1),
			11'(cfg.center_y) + 11'(dy_s1), xr, yr};
	end

	assign push = v_s2;
	assign pop = q_valid && q_ready;
	assign q_valid = fill_q != 3'd0;
	assign q_data = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			fill_q <= fill_q + {2'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= d_s2;
	end
endmodule

[rtl/rbss_back.sv]
// back part: sprite memory in four copies, bilinear filter, alpha blend
// depends on rbss_pkg
`timescale 1ns / 1ps
module rbss_back import rbss_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int FB = COORD_FRAC_DEF,
	parameter int AW = 14,
	parameter int CW = 24,
	parameter int QW = 1 + AW + 16 + 22 + 2 * CW
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	output logic q_ready,
	input logic [QW-1:0] q_data,
	output logic out_valid,
	input logic out_ready,
	output logic [10:0] out_x,
	output logic [10:0] out_y,
	output logic [7:0] out_pix
);
	localparam int DW = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int NS = 7;

	logic func;
	logic [AW-1:0] addr;
	logic [15:0] ld;
	logic [10:0] scx, scy;
	logic signed [CW-1:0] xc, yc;
	assign {func, addr, ld, scx, scy, xc, yc} = q_data;

	logic adv;
	logic [NS-1:0] v_q;
	logic [7:0] we, he;
	assign we = (32'(cfg.img_width) > MAX_DIM) ? 8'(MAX_DIM) : cfg.img_width;
	assign he = (32'(cfg.img_height) > MAX_DIM) ? 8'(MAX_DIM) : cfg.img_height;

	// output register: pipeline moves when final slot is empty or being taken
	logic ov_q;
	assign adv = !ov_q || out_ready;
	assign q_ready = adv;
	assign out_valid = ov_q;

	// stage 1: classify, split coordinates
	logic r_s1, in_s1;
	logic [DW:0] x0_s1, y0_s1;
	logic [FB-1:0] fx_s1, fy_s1;
	logic [10:0] sx_s1, sy_s1;
	logic [7:0] w_s1;
	logic inside_c;
	always_comb begin
		inside_c = (we >= 8'd2) && (he >= 8'd2) && !xc[CW-1] && !yc[CW-1]
			&& (xc < CW'({1'b0, we - 8'd1}) <<< FB) && (yc < CW'({1'b0, he - 8'd1}) <<< FB);
	end

	// load path: carried to stage 2 so a write lands in item order with the tap reads
	logic ld_en;
	logic ld_v_s1, ld_v_s2;
	logic [AW-1:0] la_s1, la_s2;
	logic [15:0] ld_s1, ld_s2;
	always_comb begin
		ld_en = q_valid && (func == FUNC_LOAD) && (32'(addr) < DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], q_valid && func == FUNC_RENDER};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
			ld_v_s2 <= 1'b0;
		end else if (adv) begin
			ld_v_s1 <= ld_en;
			ld_v_s2 <= ld_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= inside_c;
			x0_s1 <= (DW + 1)'(xc >>> FB);
			y0_s1 <= (DW + 1)'(yc >>> FB);
			fx_s1 <= xc[FB-1:0];
			fy_s1 <= yc[FB-1:0];
			sx_s1 <= scx;
			sy_s1 <= scy;
			w_s1 <= we;
			la_s1 <= addr;
			ld_s1 <= ld;
		end
	end
	assign r_s1 = v_q[0];

	// entry index = y*w + x; p00 = i, p10 = i+1, p01 = i+w, p11 = i+w+1
	logic [AW-1:0] i00_s2;
	logic [AW-1:0] ia [4];
	logic [7:0] w_s2;
	logic in_s2;
	logic [FB-1:0] fx_s2, fy_s2;
	logic [10:0] sx_s2, sy_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			i00_s2 <= AW'(y0_s1 * w_s1) + AW'(x0_s1);
			w_s2 <= w_s1;
			in_s2 <= in_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;
			la_s2 <= la_s1;
			ld_s2 <= ld_s1;
		end
	end
	always_comb begin
		ia[0] = i00_s2;
		ia[1] = i00_s2 + AW'(1);
		ia[2] = i00_s2 + AW'(w_s2);
		ia[3] = i00_s2 + AW'(w_s2) + AW'(1);
	end

	// the four taps hit four distinct addresses; four copies of the store each
	// serve one tap and all take every load write
	logic [15:0] mem0 [DEPTH];
	logic [15:0] mem1 [DEPTH];
	logic [15:0] mem2 [DEPTH];
	logic [15:0] mem3 [DEPTH];
	logic [15:0] p_s3 [4];
	always_ff @(posedge clk) begin
		if (adv && ld_v_s2) begin
			mem0[la_s2] <= ld_s2;
			mem1[la_s2] <= ld_s2;
			mem2[la_s2] <= ld_s2;
			mem3[la_s2] <= ld_s2;
		end
		if (adv) begin
			p_s3[0] <= mem0[ia[0]];
			p_s3[1] <= mem1[ia[1]];
			p_s3[2] <= mem2[ia[2]];
			p_s3[3] <= mem3[ia[3]];
		end
	end

	logic in_s3;
	logic [FB-1:0] fx_s3, fy_s3;
	logic [10:0] sx_s3, sy_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			in_s3 <= in_s2;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
		end
	end

	// stage 4: horizontal blend, both channels
	logic [FB+8:0] ta_s4, ba_s4, tg_s4, bg_s4;
	logic [FB:0] ifx;
	logic in_s4;
	logic [FB-1:0] fy_s4;
	logic [10:0] sx_s4, sy_s4;
	assign ifx = (FB + 1)'(1 << FB) - (FB + 1)'(fx_s3);
	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s4 <= (FB + 9)'(p_s3[0][15:8] * ifx + p_s3[1][15:8] * fx_s3);
			ba_s4 <= (FB + 9)'(p_s3[2][15:8] * ifx + p_s3[3][15:8] * fx_s3);
			tg_s4 <= (FB + 9)'(p_s3[0][7:0] * ifx + p_s3[1][7:0] * fx_s3);
			bg_s4 <= (FB + 9)'(p_s3[2][7:0] * ifx + p_s3[3][7:0] * fx_s3);
			in_s4 <= in_s3;
			fy_s4 <= fy_s3;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
		end
	end

	// stage 5: vertical blend and rounding
	localparam int VW = 2 * FB + 9;
	logic [FB:0] ify;
	logic [VW-1:0] va, vg;
	logic [7:0] a_s5, g_s5;
	logic [10:0] sx_s5, sy_s5;
	assign ify = (FB + 1)'(1 << FB) - (FB + 1)'(fy_s4);
	always_comb begin
		va = VW'(ta_s4 * ify) + VW'(ba_s4 * fy_s4) + VW'(1 << (2 * FB - 1));
		vg = VW'(tg_s4 * ify) + VW'(bg_s4 * fy_s4) + VW'(1 << (2 * FB - 1));
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s5 <= in_s4 ? 8'(va >> (2 * FB)) : 8'd0;
			g_s5 <= in_s4 ? 8'(vg >> (2 * FB)) : 8'd0;
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
		end
	end

	// stage 6: grey times alpha
	logic [15:0] m_s6;
	logic az_s6;
	logic [10:0] sx_s6, sy_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6 <= a_s5 * g_s5;
			az_s6 <= a_s5 == 8'd0;
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
		end
	end

	// divide by 255: q = (m + (m>>8) + 1) >> 8 is exact for m < 65535
	logic [16:0] dq;
	assign dq = 17'(m_s6) + 17'(m_s6 >> 8) + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= v_q[5] && !az_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_pix <= dq[15:8];
			out_x <= sx_s6;
			out_y <= sy_s6;
		end
	end
	logic unused;
	assign unused = r_s1 ^ v_q[6] ^ dq[16] ^ ^dq[7:0];
endmodule

[dv/rotated_bilinear_sprite_sampler_tb.sv]
// testbench for the rotated bilinear sprite sampler: loads sprites, renders rotated samples
// depends on rbss_pkg, rbss_if and the rtl top level; self-checking against its own predictor
`timescale 1ns / 1ps
module rotated_bilinear_sprite_sampler_tb;
	import rbss_pkg::*;

	localparam int IN_W = 49;
	localparam int OUT_W = 30;
	localparam int STORE_N = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int DRAIN_CYCLES = 24;
	localparam int ITEM_TARGET = 1950;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [10:0] screen_y;
		logic [10:0] screen_x;
	} pixel_t;

	// sampler predictor and the queue of pixels it still owes
	class sampler_scoreboard;
		logic [15:0] sprite[STORE_N];
		longint cos_q, sin_q;
		bit mirror;
		logic [7:0] width, height;
		logic [8:0] cx, cy;
		pixel_t owed[$];
		int errors;
		int mismatches;

		function void reset_regs();
			cos_q = 16384; sin_q = 0; mirror = 0;
			width = 128; height = 128; cx = 0; cy = 0;
			owed.delete();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_COS: cos_q = longint'($signed(val));
				REG_SIN: sin_q = longint'($signed(val));
				REG_MIRROR: mirror = val[0];
				REG_WIDTH: width = val[7:0];
				REG_HEIGHT: height = val[7:0];
				REG_CX: cx = val[8:0];
				REG_CY: cy = val[8:0];
				default: ;
			endcase
		endfunction

		function longint tap(longint idx, bit chan);
			if (idx >= STORE_N) return 0;
			return chan ? longint'(sprite[idx][15:8]) : longint'(sprite[idx][7:0]);
		endfunction

		// bilinear tap blend, coords carry eight fraction bits
		function longint blend(longint x, longint y, longint w, longint h, bit chan);
			longint x0, y0, fx, fy, i00, top, bot, v;
			if (w < 2 || h < 2) return 0;
			if (x < 0 || y < 0 || x >= (w - 1) * 256 || y >= (h - 1) * 256) return 0;
			x0 = x >> 8; y0 = y >> 8;
			fx = x & 255; fy = y & 255;
			i00 = y0 * w + x0;
			top = tap(i00, chan) * (256 - fx) + tap(i00 + 1, chan) * fx;
			bot = tap(i00 + w, chan) * (256 - fx) + tap(i00 + w + 1, chan) * fx;
			v = top * (256 - fy) + bot * fy;
			return (v + 32768) >> 16;
		endfunction

		function void note_item(logic [IN_W-1:0] d);
			longint dx, dy, sx, sy, x, y, w, h, a, g;
			pixel_t p;
			if (d[0] == FUNC_LOAD) begin
				sprite[d[14:1]] = {d[30:23], d[22:15]};
				return;
			end
			dx = longint'($signed(d[39:31]));
			dy = longint'($signed(d[48:40]));
			w = width > 128 ? 128 : width;
			h = height > 128 ? 128 : height;
			sx = dx * cos_q + dy * sin_q;
			sy = dy * cos_q - dx * sin_q;
			if (mirror) sx = -sx;
			// drop six of fourteen fraction bits, round half up
			x = ((sx + 32) >>> 6) + (w << 7);
			y = ((sy + 32) >>> 6) + (h << 7);
			a = blend(x, y, w, h, 1);
			if (a == 0) return;
			g = blend(x, y, w, h, 0);
			p.screen_x = 11'(longint'(cx) + dx);
			p.screen_y = 11'(longint'(cy) + dy);
			p.pixel_value = 8'((g * a) / 255);
			owed.push_back(p);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (owed.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel x=%0d y=%0d v=%0d", $signed(got.screen_x),
						$signed(got.screen_y), got.pixel_value);
				return;
			end
			want = owed.pop_front();
			if (got !== want) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("pixel mismatch: want x=%0d y=%0d v=%0d, got x=%0d y=%0d v=%0d",
						$signed(want.screen_x), $signed(want.screen_y), want.pixel_value,
						$signed(got.screen_x), $signed(got.screen_y), got.pixel_value);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	rbss_if #(.W(IN_W)) in_ch ();
	rbss_if #(.W(OUT_W)) out_ch ();

	rotated_bilinear_sprite_sampler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	sampler_scoreboard sb;
	int src_idle_pct;
	int snk_idle_pct;
	int items_sent;
	int loaded_upto;	// entries below this index have been written

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// idle profile follows progress: receiver-heavy gaps, then sender-heavy, then none
	function void update_idling();
		if (items_sent < ITEM_TARGET / 3) begin
			src_idle_pct = 26; snk_idle_pct = 53;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			src_idle_pct = 53; snk_idle_pct = 26;
		end else begin
			src_idle_pct = 0; snk_idle_pct = 0;
		end
	endfunction

	// drive one item, holding valid until accepted
	task automatic send_item(logic [IN_W-1:0] d);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = d;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(d);
		items_sent++;
		update_idling();
	endtask

	task automatic load_entry(int addr, logic [7:0] gray, logic [7:0] alpha);
		send_item({9'($urandom), 9'($urandom), alpha, gray, 14'(addr), FUNC_LOAD});
	endtask

	task automatic render(int ox, int oy);
		send_item({9'(oy), 9'(ox), 8'($urandom), 8'($urandom), 14'($urandom), FUNC_RENDER});
	endtask

	// release the channel and wait out every owed pixel plus pipeline slack
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = CFG_W'(val);
		@(posedge clk);
		sb.set_reg(idx, CFG_W'(val));
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int c, int s, int m, int w, int h, int x, int y);
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
		write_reg(REG_MIRROR, m);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_CX, x);
		write_reg(REG_CY, y);
	endtask

	// make sure every entry the current image can reach has been written
	task automatic fill_image(int w, int h);
		int need;
		need = (w > 128 ? 128 : w) * (h > 128 ? 128 : h);
		if (w < 2 || h < 2) need = 0;
		while (loaded_upto < need) begin
			load_entry(loaded_upto, 8'($urandom),
				($urandom_range(4) == 0) ? 8'd0 : 8'($urandom));
			loaded_upto++;
		end
	endtask

	// receiver: ready decided at the falling edge, pixels taken at the rising edge
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = arst_n && ($urandom_range(99) >= snk_idle_pct);
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) sb.check_pixel(pixel_t'(out_ch.data));
		end
	end

	initial begin
		#20_000_000;
		$display("rotated_bilinear_sprite_sampler_tb: FAIL");
		$finish;
	end

	initial begin
		int phase, w, h, span, n, ox, oy;
		real ang;
		sb = new();
		sb.reset_regs();
		sb.errors = 0;
		sb.mismatches = 0;
		items_sent = 0;
		loaded_upto = 0;
		update_idling();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: a 4x4 sprite with corner values, then edge offsets
		configure(16384, 0, 0, 4, 4, 0, 0);
		load_entry(0, 8'd255, 8'd255);
		load_entry(1, 8'd0, 8'd255);
		load_entry(2, 8'd255, 8'd0);
		load_entry(3, 8'd0, 8'd0);
		load_entry(4, 8'd128, 8'd1);
		load_entry(5, 8'd255, 8'd255);
		load_entry(6, 8'd255, 8'd255);
		load_entry(7, 8'd1, 8'd128);
		load_entry(8, 8'd200, 8'd255);
		load_entry(9, 8'd255, 8'd255);
		load_entry(10, 8'd255, 8'd255);
		load_entry(11, 8'd17, 8'd99);
		load_entry(12, 8'd0, 8'd0);
		load_entry(13, 8'd255, 8'd0);
		load_entry(14, 8'd0, 8'd255);
		load_entry(15, 8'd255, 8'd255);
		loaded_upto = 16;
		load_entry(16383, 8'd255, 8'd255);	// top of the store, outside this image
		render(0, 0);
		render(-1, -1);
		render(1, 0);
		render(-2, -2);	// corner of the image
		render(1, 1);	// right/bottom edge, reads as outside
		render(-256, 255);	// far outside
		render(255, -256);
		render(-3, 0);	// left of the image, reads as outside
		drain();

		// phases over several register settings; pause for full drain between them
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: begin w = 2; h = 2; configure(16384, 0, 0, w, h, 0, 0); end
				1: begin w = 128; h = 2; configure(-16384, 0, 1, w, h, 511, 511); end
				2: begin w = 2; h = 128; configure(0, 16384, 0, w, h, 100, 300); end
				3: begin w = 255; h = 2; configure(0, -16384, 1, w, h, 7, 400); end
				4: begin w = 2; h = 200; configure(11585, 11585, 0, w, h, 256, 255); end
				5: begin w = 1; h = 9; configure(16384, 0, 0, w, h, 20, 20); end
				6: begin w = 9; h = 0; configure(16384, 0, 1, w, h, 30, 30); end
				7: begin w = 16; h = 16; configure(16384, 16384, 0, w, h, 0, 511); end
				default: begin
					if ($urandom_range(7) == 0) begin
						w = 128; h = 2;
					end else begin
						w = $urandom_range(2, 16); h = $urandom_range(2, 16);
					end
					ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
					configure(int'($floor(16384.0 * $cos(ang) + 0.5)),
						int'($floor(16384.0 * $sin(ang) + 0.5)),
						$urandom_range(1), w, h, $urandom_range(511), $urandom_range(511));
				end
			endcase
			fill_image(w, h);
			span = ((w > h ? w : h) > 128 ? 128 : (w > h ? w : h)) / 2 + 3;
			for (n = 0; n < 100; n++) begin
				if ($urandom_range(9) < 2) begin
					// rewrite an entry inside the image, or anywhere in the store
					if ($urandom_range(3) == 0 || loaded_upto == 0)
						load_entry($urandom_range(STORE_N - 1), 8'($urandom), 8'($urandom));
					else
						load_entry($urandom_range(loaded_upto - 1), 8'($urandom), 8'($urandom));
				end else if ($urandom_range(6) == 0) begin
					render($urandom_range(511) - 256, $urandom_range(511) - 256);
				end else begin
					ox = $urandom_range(2 * span) - span;
					oy = $urandom_range(2 * span) - span;
					render(ox, oy);
				end
			end
			drain();
			phase++;
		end

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("rotated_bilinear_sprite_sampler_tb: PASS");
		else
			$display("rotated_bilinear_sprite_sampler_tb: FAIL");
		$finish;
	end
endmodule
